// ===== design/lrss_pkg.sv =====
// ============================================================================
// lrss_pkg
// Shared types, constants and tables of the looping random shift sequencer.
// ============================================================================
`default_nettype none

package lrss_pkg;

    // Widths
    localparam int unsigned LOOP_W  = 32;
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned CV_W    = 5;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned PROB_W  = 17;
    localparam int unsigned PROG_W  = 6;
    localparam int unsigned DRIFT_W = 14;

    // Default cap on the loop length
    localparam int unsigned MAX_LENGTH_DEF = 32;

    // Probabilities, unsigned Q0.16
    localparam logic [PROB_W-1:0] PROB_MIN   = 17'd3277;
    localparam logic [PROB_W-1:0] PROB_MAX   = 17'd32768;
    localparam logic [PROB_W-1:0] PROB_RESET = 17'd13107;

    // Draws are scaled by this to compare against Q0.16
    localparam int unsigned DRAW_SCALE = 1000;

    // x / 10 == (x * 52429) >> 19 for any 16-bit x
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int unsigned DIV10_SHIFT = 19;
    localparam logic [15:0] DIV10_ROUND = 16'd5;

    // Morph events with mismatched lengths before the length switches
    localparam logic [PROG_W-1:0] MORPH_STEPS = 6'd50;

    // Reset values of registers
    localparam logic [LOOP_W-1:0] SEED_RESET     = 32'd0;
    localparam logic [TICK_W-1:0] INTERVAL_RESET = 16'd256;

    // Length pick codes (any other code selects the long loop)
    localparam logic [1:0] PICK_SHORT = 2'd0;
    localparam logic [1:0] PICK_MID   = 2'd1;

    // Register indexes
    typedef enum logic [0:0] {
        CFG_SEED_PATTERN   = 1'b0,
        CFG_MORPH_INTERVAL = 1'b1
    } cfg_index_t;

    // Input item
    typedef struct packed {
        logic [9:0] chance_draw;
        logic       random_bit;
        logic [6:0] drift_draw;
        logic [3:0] change_draw;
        logic [1:0] length_pick;
    } item_t;

    // Result item
    typedef struct packed {
        logic [CV_W-1:0]   cv_code;
        logic [LOOP_W-1:0] loop_bits;
        logic [POS_W-1:0]  step_position;
        logic [LEN_W-1:0]  loop_length;
    } result_t;

    // Decoded register writes
    typedef struct packed {
        logic              seed_load;
        logic              interval_load;
        logic [LOOP_W-1:0] data;
    } cfg_wr_t;

    // Length switch from the morph unit to the loop
    typedef struct packed {
        logic             length_switch;
        logic [LEN_W-1:0] next_length;
    } morph_status_t;

    // Drift table: round(draw * 65.536), draws 0..127
    localparam int unsigned DRIFT_ENTRIES = 128;
    localparam int unsigned DRIFT_HALF    = 500;

    typedef logic [DRIFT_ENTRIES-1:0][DRIFT_W-1:0] drift_tab_t;

    function automatic drift_tab_t build_drift_table();
        drift_tab_t tab;
        for (int i = 0; i < DRIFT_ENTRIES; i++)
        begin
            tab[i] = DRIFT_W'((i * 65536 + DRIFT_HALF) / DRAW_SCALE);
        end
        return tab;
    endfunction

    localparam drift_tab_t DRIFT_TABLE = build_drift_table();

    // Mask of the low len bits, all ones from LOOP_W up
    function automatic logic [LOOP_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [LOOP_W-1:0] mask;
        if (len >= LEN_W'(LOOP_W))
        begin
            mask = '1;
        end
        else
        begin
            mask = (LOOP_W'(1) << len) - LOOP_W'(1);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== design/lrss_morph.sv =====
// ============================================================================
// lrss_morph
// Tick counter, replace probability drift and smoothing, loop length switch.
// ============================================================================
`default_nettype none

module lrss_morph #(
    parameter int unsigned MAX_LENGTH = lrss_pkg::MAX_LENGTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lrss_pkg::cfg_wr_t             cfg,
    input  wire logic                          tick,
    input  wire lrss_pkg::item_t               item,
    output logic [lrss_pkg::LEN_W-1:0]         active_length,
    output logic [lrss_pkg::PROB_W-1:0]        replace_prob,
    output lrss_pkg::morph_status_t            status
);
    import lrss_pkg::*;

    // Lengths after the cap
    localparam logic [LEN_W-1:0] LEN_SHORT = LEN_W'((MAX_LENGTH < 8)  ? MAX_LENGTH : 8);
    localparam logic [LEN_W-1:0] LEN_MID   = LEN_W'((MAX_LENGTH < 16) ? MAX_LENGTH : 16);
    localparam logic [LEN_W-1:0] LEN_LONG  = LEN_W'((MAX_LENGTH < 32) ? MAX_LENGTH : 32);

    logic [TICK_W-1:0] interval_reg;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [PROB_W-1:0] replace_prob_reg, replace_prob_next;
    logic [PROB_W-1:0] target_prob_reg, target_prob_next;
    logic [LEN_W-1:0]  active_length_reg, active_length_next;
    logic [LEN_W-1:0]  wanted_length_reg, wanted_length_next;
    logic [PROG_W-1:0] progress_reg, progress_next;

    logic [TICK_W-1:0]  tick_inc;
    logic               morph;
    logic [DRIFT_W-1:0] drift;
    logic [PROB_W:0]    target_sum;
    logic [PROB_W-1:0]  target_clamped;
    logic               step_up;
    logic [15:0]        mag;
    logic [15:0]        mag_round;
    logic [31:0]        step_prod;
    logic [PROB_W-1:0]  step;
    logic [LEN_W-1:0]   picked_length;
    logic [PROG_W-1:0]  progress_inc;
    logic               length_done;

    // Tick counter
    assign tick_inc = tick_count_reg + TICK_W'(1);
    assign morph    = tick && (tick_inc >= interval_reg);

    // Target drift and clamp
    assign drift      = DRIFT_TABLE[item.drift_draw];
    assign target_sum = {1'b0, target_prob_reg} + (PROB_W + 1)'(drift)
                        - {1'b0, PROB_MIN};

    always_comb
    begin
        if (target_sum < {1'b0, PROB_MIN})
        begin
            target_clamped = PROB_MIN;
        end
        else if (target_sum > {1'b0, PROB_MAX})
        begin
            target_clamped = PROB_MAX;
        end
        else
        begin
            target_clamped = target_sum[PROB_W-1:0];
        end
    end

    // Smoothing: a tenth of the gap, magnitude rounded half away from zero
    assign step_up   = target_clamped >= replace_prob_reg;
    assign mag       = step_up ? 16'(target_clamped - replace_prob_reg)
                               : 16'(replace_prob_reg - target_clamped);
    assign mag_round = mag + DIV10_ROUND;
    assign step_prod = 32'(mag_round) * 32'(DIV10_MUL);
    assign step      = PROB_W'(step_prod >> DIV10_SHIFT);

    // Wanted length pick
    always_comb
    begin
        case (item.length_pick)
            PICK_SHORT: picked_length = LEN_SHORT;
            PICK_MID:   picked_length = LEN_MID;
            default:    picked_length = LEN_LONG;
        endcase
    end

    assign progress_inc = progress_reg + PROG_W'(1);
    assign length_done  = progress_inc >= MORPH_STEPS;

    // Next state
    always_comb
    begin
        tick_count_next    = tick_count_reg;
        target_prob_next   = target_prob_reg;
        replace_prob_next  = replace_prob_reg;
        wanted_length_next = wanted_length_reg;
        active_length_next = active_length_reg;
        progress_next      = progress_reg;
        if (tick)
        begin
            tick_count_next = morph ? '0 : tick_inc;
        end
        if (morph)
        begin
            target_prob_next  = target_clamped;
            replace_prob_next = step_up ? replace_prob_reg + step
                                        : replace_prob_reg - step;
            if (item.change_draw == 4'd0)
            begin
                wanted_length_next = picked_length;
            end
            if (active_length_reg != wanted_length_next)
            begin
                if (length_done)
                begin
                    progress_next      = '0;
                    active_length_next = wanted_length_next;
                end
                else
                begin
                    progress_next = progress_inc;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg      <= INTERVAL_RESET;
            tick_count_reg    <= '0;
            target_prob_reg   <= PROB_RESET;
            replace_prob_reg  <= PROB_RESET;
            wanted_length_reg <= LEN_MID;
            active_length_reg <= LEN_MID;
            progress_reg      <= '0;
        end
        else
        begin
            if (cfg.interval_load)
            begin
                interval_reg <= cfg.data[TICK_W-1:0];
            end
            tick_count_reg    <= tick_count_next;
            target_prob_reg   <= target_prob_next;
            replace_prob_reg  <= replace_prob_next;
            wanted_length_reg <= wanted_length_next;
            active_length_reg <= active_length_next;
            progress_reg      <= progress_next;
        end
    end

    assign active_length        = active_length_reg;
    assign replace_prob         = replace_prob_reg;
    assign status.length_switch = morph && (active_length_next != active_length_reg);
    assign status.next_length   = active_length_next;

`ifndef NO_ASSERTIONS
    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        replace_prob_reg >= PROB_MIN && replace_prob_reg <= PROB_MAX)
        else $error("replace probability left its clamp range");

    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        target_prob_reg >= PROB_MIN && target_prob_reg <= PROB_MAX)
        else $error("target probability left its clamp range");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_length_reg >= LEN_SHORT && active_length_reg <= LEN_LONG)
        else $error("active length outside the capped range");

    a_progress_bound: assert property (@(posedge clk) disable iff (!rst_n)
        progress_reg < MORPH_STEPS)
        else $error("length progress reached the switch count");

    a_switch_only_on_morph: assert property (@(posedge clk) disable iff (!rst_n)
        !morph |=> $stable(active_length_reg))
        else $error("length changed without a morph event");
`endif

endmodule

`default_nettype wire

// ===== design/lrss_loop.sv =====
// ============================================================================
// lrss_loop
// Loop register rotation with random replacement, and step position.
// ============================================================================
`default_nettype none

module lrss_loop (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lrss_pkg::cfg_wr_t             cfg,
    input  wire logic                          tick,
    input  wire lrss_pkg::item_t               item,
    input  wire logic [lrss_pkg::LEN_W-1:0]    active_length,
    input  wire logic [lrss_pkg::PROB_W-1:0]   replace_prob,
    input  wire lrss_pkg::morph_status_t       status,
    output lrss_pkg::result_t                  result
);
    import lrss_pkg::*;

    localparam int unsigned CMP_W = 27;

    logic [LOOP_W-1:0] loop_reg, loop_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    logic [LEN_W-1:0]  top_idx;
    logic              top_bit;
    logic [CMP_W-1:0]  draw_scaled;
    logic [CMP_W-1:0]  prob_scaled;
    logic              replace;
    logic              new_bit;
    logic [LOOP_W-1:0] rotated;
    logic [LEN_W-1:0]  pos_inc;

    // Replace test: chance/1000 < prob/65536
    assign draw_scaled = CMP_W'({item.chance_draw, 16'h0000});
    assign prob_scaled = CMP_W'(replace_prob) * CMP_W'(DRAW_SCALE);
    assign replace     = draw_scaled < prob_scaled;

    // Rotate within the active length
    assign top_idx = active_length - LEN_W'(1);
    assign top_bit = loop_reg[top_idx[POS_W-1:0]];
    assign new_bit = replace ? item.random_bit : top_bit;
    assign rotated = {loop_reg[LOOP_W-2:0], new_bit} & len_mask(active_length);

    // A length switch in the same tick masks to the new length
    assign loop_next = status.length_switch ? (rotated & len_mask(status.next_length))
                                            : rotated;

    // Position advance wraps at the length in force before the morph
    assign pos_inc  = {1'b0, pos_reg} + LEN_W'(1);
    assign pos_next = (pos_inc >= active_length) ? '0 : pos_inc[POS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_reg <= SEED_RESET;
            pos_reg  <= '0;
        end
        else
        begin
            if (cfg.seed_load)
            begin
                loop_reg <= cfg.data;
            end
            else if (tick)
            begin
                loop_reg <= loop_next;
            end
            if (tick)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // Result of this tick
    assign result.cv_code       = loop_next[CV_W-1:0];
    assign result.loop_bits     = loop_next;
    assign result.step_position = pos_next;
    assign result.loop_length   = status.length_switch ? status.next_length : active_length;

endmodule

`default_nettype wire

// ===== design/looping_random_shift_sequencer.sv =====
// ============================================================================
// looping_random_shift_sequencer
// Looping shift register sequencer with random bit replacement and slow
// drift of replace probability and loop length.
// ============================================================================
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------
//  item     | item_valid / item_ready    | item   (lrss_pkg::item_t)
//  result   | result_valid / result_ready| result (lrss_pkg::result_t)
//  cfg      | cfg_write, no wait         | cfg_index, cfg_data
//
//  One item per cycle sustained while result_ready stays high. An accepted
//  item sits in the input register, is processed by single-pass logic when
//  the result register can take it, and its result is registered there.
//  Throughput is set by the state update in that pass (loop, tick counter,
//  probability smoothing with one 16x16 multiply).
//  A stalled result holds the result register; the input register still takes
//  one more item, then item_ready drops.
//  rst_n is asynchronous, active low; no clearing pass after reset.
// ============================================================================
`default_nettype none

module looping_random_shift_sequencer #(
    parameter int unsigned MAX_LENGTH = lrss_pkg::MAX_LENGTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire lrss_pkg::item_t               item,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output lrss_pkg::result_t                  result,
    input  wire logic                          cfg_write,
    input  wire lrss_pkg::cfg_index_t          cfg_index,
    input  wire logic [lrss_pkg::LOOP_W-1:0]   cfg_data
);
    import lrss_pkg::*;

    logic          in_valid_reg, in_valid_next;
    item_t         in_item_reg;
    logic          out_valid_reg, out_valid_next;
    result_t       out_item_reg;

    logic          in_load;
    logic          fire;
    cfg_wr_t       cfg;
    logic [LEN_W-1:0]  active_length;
    logic [PROB_W-1:0] replace_prob;
    morph_status_t status;
    result_t       result_comb;

    // Register write decode
    always_comb
    begin
        cfg.seed_load     = 1'b0;
        cfg.interval_load = 1'b0;
        cfg.data          = cfg_data;
        unique case (cfg_index)
            CFG_SEED_PATTERN:   cfg.seed_load     = cfg_write;
            CFG_MORPH_INTERVAL: cfg.interval_load = cfg_write;
            default:            cfg.seed_load     = 1'b0;
        endcase
    end

    // Handshake control
    assign fire       = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || fire;
    assign in_load    = item_valid && item_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg <= item;
        end
        if (fire)
        begin
            out_item_reg <= result_comb;
        end
    end

    lrss_morph #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_morph (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .tick          (fire),
        .item          (in_item_reg),
        .active_length (active_length),
        .replace_prob  (replace_prob),
        .status        (status)
    );

    lrss_loop u_loop (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .tick          (fire),
        .item          (in_item_reg),
        .active_length (active_length),
        .replace_prob  (replace_prob),
        .status        (status),
        .result        (result_comb)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

`ifndef NO_ASSERTIONS
    a_fire_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_item_reg))
        else $error("waiting item lost from the input register");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> in_valid_reg && out_valid_reg && !result_ready)
        else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire
